>>> rtl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix: shared definitions
// Width helpers that the top level and the divider lanes both derive from.
// ----------------------------------------------------------------------------
package qrm_pkg;

   localparam int MAX_EFF_WIDTH = 30;

   function automatic int eff_width(input int data_width);
      return (data_width > MAX_EFF_WIDTH) ? MAX_EFF_WIDTH : data_width;
   endfunction

endpackage

>>> rtl/qrm_if.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix: channel interfaces
// Valid/ready channels for the quaternion request and the matrix response.
// ----------------------------------------------------------------------------
interface qrm_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] qw;
   logic signed [DATA_WIDTH-1:0] qx;
   logic signed [DATA_WIDTH-1:0] qy;
   logic signed [DATA_WIDTH-1:0] qz;

   modport source (output valid, qw, qx, qy, qz, input ready);
   modport sink   (input valid, qw, qx, qy, qz, output ready);
endinterface

interface qrm_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] m00;
   logic signed [DATA_WIDTH-1:0] m01;
   logic signed [DATA_WIDTH-1:0] m02;
   logic signed [DATA_WIDTH-1:0] m10;
   logic signed [DATA_WIDTH-1:0] m11;
   logic signed [DATA_WIDTH-1:0] m12;
   logic signed [DATA_WIDTH-1:0] m20;
   logic signed [DATA_WIDTH-1:0] m21;
   logic signed [DATA_WIDTH-1:0] m22;
   logic                         degenerate;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
                   output ready);
endinterface

>>> rtl/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix
// Converts a fixed-point quaternion into the nine entries of its normalized
// 3x3 rotation matrix, with a flag for a zero-magnitude input.
// ----------------------------------------------------------------------------
// The block accepts one quaternion beat per cycle unless backpressure stalls
// the pipeline, and returns one matrix beat for each one: one stage
// loads the components, one forms the ten products, one forms the squared
// norm and numerators, FRAC_BITS+1 stages divide each entry one quotient bit
// at a time, and the last stage rounds, saturates and holds the result.
// Each stage holds its beat under backpressure and empty stages still fill.
module quaternion_to_rotation_matrix #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic      clock,
   input  logic      reset,
   qrm_req_if.sink   req_ch,
   qrm_rsp_if.source rsp_ch
);
   import qrm_pkg::*;

   localparam int EW   = eff_width(DATA_WIDTH);
   localparam int PRE  = DATA_WIDTH - EW;
   localparam int VW   = EW + 1;
   localparam int PW   = 2 * VW;
   localparam int NWU  = 2 * EW + 1;
   localparam int SW   = PW + 3;
   localparam int CW   = ((FRAC_BITS > DATA_WIDTH) ? FRAC_BITS : DATA_WIDTH) + 3;
   localparam int NS   = FRAC_BITS + 5;
   localparam int DIV0 = 3;

   localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;
   localparam logic signed [CW-1:0] HI  = (CW'(1) <<< (DATA_WIDTH - 1)) - CW'(1);
   localparam logic signed [CW-1:0] LO  = -HI - CW'(1);

   function automatic logic signed [VW-1:0] load_comp(input logic [DATA_WIDTH-1:0] raw);
      logic [DATA_WIDTH-1:0] mag;
      logic [DATA_WIDTH-1:0] shifted;
      logic signed [VW-1:0]  ext;
      mag     = raw[DATA_WIDTH-1] ? (~raw + 1'b1) : raw;
      shifted = mag >> PRE;
      ext     = {1'b0, shifted[EW-1:0]};
      return raw[DATA_WIDTH-1] ? -ext : ext;
   endfunction

   function automatic logic signed [CW-1:0] clamp(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      r = v;
      if (r > ONE) r = ONE;
      if (r < -ONE) r = -ONE;
      if (r > HI) r = HI;
      if (r < LO) r = LO;
      return r;
   endfunction

   logic [NS-1:0] v_ff;
   logic [NS:0]   en;

   assign en[NS] = rsp_ch.ready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? req_ch.valid : v_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign req_ch.ready = en[0];

   // Stage 0: components w, x, y, z.
   logic signed [VW-1:0] comp_ff [0:3];
   always_ff @(posedge clock) begin
      if (en[0]) begin
         comp_ff[0] <= load_comp(req_ch.qw);
         comp_ff[1] <= load_comp(req_ch.qx);
         comp_ff[2] <= load_comp(req_ch.qy);
         comp_ff[3] <= load_comp(req_ch.qz);
      end
   end

   // Stage 1: ww, xx, yy, zz, xy, wz, xz, wy, yz, wx.
   logic signed [PW-1:0] prod_ff [0:9];
   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_ff[0] <= comp_ff[0] * comp_ff[0];
         prod_ff[1] <= comp_ff[1] * comp_ff[1];
         prod_ff[2] <= comp_ff[2] * comp_ff[2];
         prod_ff[3] <= comp_ff[3] * comp_ff[3];
         prod_ff[4] <= comp_ff[1] * comp_ff[2];
         prod_ff[5] <= comp_ff[0] * comp_ff[3];
         prod_ff[6] <= comp_ff[1] * comp_ff[3];
         prod_ff[7] <= comp_ff[0] * comp_ff[2];
         prod_ff[8] <= comp_ff[2] * comp_ff[3];
         prod_ff[9] <= comp_ff[0] * comp_ff[1];
      end
   end

   // Stage 2: squared norm and numerator magnitudes.
   logic signed [SW-1:0] p    [0:9];
   logic signed [SW-1:0] nsum;
   logic signed [SW-1:0] num  [0:8];
   logic [NWU-1:0]       n_ff;
   logic [NWU-1:0]       a_ff   [0:8];
   logic                 sgn_ff [0:8];
   logic                 deg2_ff;

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         p[i] = SW'(prod_ff[i]);
      end
      nsum   = p[0] + p[1] + p[2] + p[3];
      num[0] = nsum - ((p[2] + p[3]) <<< 1);
      num[1] = (p[4] - p[5]) <<< 1;
      num[2] = (p[6] + p[7]) <<< 1;
      num[3] = (p[4] + p[5]) <<< 1;
      num[4] = nsum - ((p[1] + p[3]) <<< 1);
      num[5] = (p[8] - p[9]) <<< 1;
      num[6] = (p[6] - p[7]) <<< 1;
      num[7] = (p[8] + p[9]) <<< 1;
      num[8] = nsum - ((p[1] + p[2]) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         n_ff    <= nsum[NWU-1:0];
         deg2_ff <= nsum == '0;
         for (int i = 0; i < 9; i++) begin
            sgn_ff[i] <= num[i][SW-1];
            a_ff[i]   <= num[i][SW-1] ? NWU'(-num[i]) : NWU'(num[i]);
         end
      end
   end

   // Divider stages.
   logic [FRAC_BITS:0] q_w   [0:8];
   logic [NWU-1:0]     rem_w [0:8];
   logic [NWU-1:0]     n_w   [0:8];
   logic               neg_w [0:8];

   for (genvar i = 0; i < 9; i++) begin : g_lane
      qrm_div_lane #(
         .DATA_WIDTH (DATA_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .stage_en (en[DIV0 +: FRAC_BITS + 1]),
         .a_in     (a_ff[i]),
         .n_in     (n_ff),
         .neg_in   (sgn_ff[i]),
         .q_out    (q_w[i]),
         .rem_out  (rem_w[i]),
         .n_out    (n_w[i]),
         .neg_out  (neg_w[i])
      );
   end

   logic degp_ff [0:FRAC_BITS];
   for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_deg
      always_ff @(posedge clock) begin
         if (en[DIV0 + j]) begin
            degp_ff[j] <= (j == 0) ? deg2_ff : degp_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   // Output stage: round, pick identity for a zero norm, saturate.
   logic signed [DATA_WIDTH-1:0] m_ff [0:8];
   logic                         deg_out_ff;
   logic signed [CW-1:0]         val  [0:8];

   always_comb begin
      logic [NWU-1:0]       d;
      logic [FRAC_BITS+1:0] qr;
      logic signed [CW-1:0] sv;
      for (int i = 0; i < 9; i++) begin
         d  = n_w[i] - rem_w[i];
         qr = {1'b0, q_w[i]} + ((rem_w[i] >= d) ? 1'b1 : 1'b0);
         sv = CW'(qr);
         if (degp_ff[FRAC_BITS]) begin
            val[i] = (i % 4 == 0) ? ONE : '0;
         end else begin
            val[i] = neg_w[i] ? -sv : sv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         deg_out_ff <= degp_ff[FRAC_BITS];
         for (int i = 0; i < 9; i++) begin
            m_ff[i] <= DATA_WIDTH'(clamp(val[i]));
         end
      end
   end

   assign rsp_ch.valid      = v_ff[NS-1];
   assign rsp_ch.m00        = m_ff[0];
   assign rsp_ch.m01        = m_ff[1];
   assign rsp_ch.m02        = m_ff[2];
   assign rsp_ch.m10        = m_ff[3];
   assign rsp_ch.m11        = m_ff[4];
   assign rsp_ch.m12        = m_ff[5];
   assign rsp_ch.m20        = m_ff[6];
   assign rsp_ch.m21        = m_ff[7];
   assign rsp_ch.m22        = m_ff[8];
   assign rsp_ch.degenerate = deg_out_ff;

   a_deg_offdiag : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |->
         rsp_ch.m01 == '0 && rsp_ch.m10 == '0 && rsp_ch.m12 == '0 && rsp_ch.m21 == '0)
      else $error("degenerate beat carries a nonzero off-diagonal entry");

   a_ready_empty : assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> req_ch.ready)
      else $error("input refused while the first stage is empty");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && v_ff[NS-2] && !rsp_ch.ready |=> v_ff[NS-1] && v_ff[NS-2])
      else $error("stalled pipeline dropped a beat");

endmodule

>>> rtl/qrm_div_lane.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix: divider lane
// Pipelined restoring division of one numerator magnitude by the squared
// norm, one quotient bit per stage, integer bit first.
// ----------------------------------------------------------------------------
module qrm_div_lane #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14,
   localparam int NWU = 2 * qrm_pkg::eff_width(DATA_WIDTH) + 1
) (
   input  logic                 clock,
   input  logic [FRAC_BITS:0]   stage_en,
   input  logic [NWU-1:0]       a_in,
   input  logic [NWU-1:0]       n_in,
   input  logic                 neg_in,
   output logic [FRAC_BITS:0]   q_out,
   output logic [NWU-1:0]       rem_out,
   output logic [NWU-1:0]       n_out,
   output logic                 neg_out
);
   import qrm_pkg::*;

   logic [FRAC_BITS:0] q_ff   [0:FRAC_BITS];
   logic [NWU-1:0]     rem_ff [0:FRAC_BITS];
   logic [NWU-1:0]     n_ff   [0:FRAC_BITS];
   logic               neg_ff [0:FRAC_BITS];

   for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_stage
      if (j == 0) begin : g_int
         logic ge;
         assign ge = a_in >= n_in;
         always_ff @(posedge clock) begin
            if (stage_en[0]) begin
               q_ff[0]   <= {{FRAC_BITS{1'b0}}, ge};
               rem_ff[0] <= ge ? (a_in - n_in) : a_in;
               n_ff[0]   <= n_in;
               neg_ff[0] <= neg_in;
            end
         end
      end else begin : g_frac
         logic [NWU:0] r2;
         logic [NWU:0] diff;
         logic         ge;
         assign r2   = {rem_ff[j-1], 1'b0};
         assign ge   = r2 >= {1'b0, n_ff[j-1]};
         assign diff = r2 - {1'b0, n_ff[j-1]};
         always_ff @(posedge clock) begin
            if (stage_en[j]) begin
               q_ff[j]   <= {q_ff[j-1][FRAC_BITS-1:0], ge};
               rem_ff[j] <= ge ? diff[NWU-1:0] : r2[NWU-1:0];
               n_ff[j]   <= n_ff[j-1];
               neg_ff[j] <= neg_ff[j-1];
            end
         end
      end
   end

   assign q_out   = q_ff[FRAC_BITS];
   assign rem_out = rem_ff[FRAC_BITS];
   assign n_out   = n_ff[FRAC_BITS];
   assign neg_out = neg_ff[FRAC_BITS];

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix testbench
// Drives quaternion beats with random gaps and response stalls, predicts each
// normalized rotation matrix in exact integer arithmetic and compares every
// returned beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 16;
   localparam int FB = 14;
   localparam int ONE = 1 << FB;
   localparam int RANDOM_BEATS = 1800;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [DW-1:0] entry_type;
   typedef struct packed {
      entry_type m00, m01, m02, m10, m11, m12, m20, m21, m22;
      logic      degenerate;
   } matrix_type;
   typedef struct packed {
      entry_type  w, x, y, z;
      logic       known;
      matrix_type m;
   } quat_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qrm_req_if #(.DATA_WIDTH(DW)) req_ch ();
   qrm_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   quaternion_to_rotation_matrix #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #5 clock = ~clock;

   matrix_type pending_matrices[$];
   int      mismatches = 0;
   int      matrices_seen = 0;
   int      degenerate_seen = 0;
   longint  cycle_count = 0;
   bit      calm_window = 1'b0;
   bit      hold_off = 1'b0;

   function automatic longint rounded_ratio(longint num, longint n);
      longint a, q, rem;
      bit neg;
      neg = num < 0;
      a = neg ? -num : num;
      q = a / n;
      rem = a - q * n;
      if (q > 1) begin
         q = 1;
         rem = 0;
      end
      for (int i = 0; i < FB; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= n) begin
            rem -= n;
            q |= 1;
         end
      end
      if (rem >= n - rem) q++;
      return neg ? -q : q;
   endfunction

   function automatic entry_type clamp_entry(longint v);
      if (v > ONE) v = ONE;
      if (v < -ONE) v = -ONE;
      return entry_type'(v);
   endfunction

   function automatic matrix_type rotation_of(entry_type qw, entry_type qx, entry_type qy,
                                              entry_type qz);
      longint w, x, y, z, ww, xx, yy, zz, n;
      matrix_type r;
      w = qw; x = qx; y = qy; z = qz;
      ww = w * w; xx = x * x; yy = y * y; zz = z * z;
      n = ww + xx + yy + zz;
      if (n == 0) begin
         r = '0;
         r.m00 = clamp_entry(ONE);
         r.m11 = clamp_entry(ONE);
         r.m22 = clamp_entry(ONE);
         r.degenerate = 1'b1;
         return r;
      end
      r.m00 = clamp_entry(rounded_ratio(n - 2 * (yy + zz), n));
      r.m01 = clamp_entry(rounded_ratio(2 * (x * y - w * z), n));
      r.m02 = clamp_entry(rounded_ratio(2 * (x * z + w * y), n));
      r.m10 = clamp_entry(rounded_ratio(2 * (x * y + w * z), n));
      r.m11 = clamp_entry(rounded_ratio(n - 2 * (xx + zz), n));
      r.m12 = clamp_entry(rounded_ratio(2 * (y * z - w * x), n));
      r.m20 = clamp_entry(rounded_ratio(2 * (x * z - w * y), n));
      r.m21 = clamp_entry(rounded_ratio(2 * (y * z + w * x), n));
      r.m22 = clamp_entry(rounded_ratio(n - 2 * (xx + yy), n));
      r.degenerate = 1'b0;
      return r;
   endfunction

   function automatic quat_row_type row(int w, int x, int y, int z);
      quat_row_type r;
      r = '0;
      r.w = entry_type'(w); r.x = entry_type'(x); r.y = entry_type'(y); r.z = entry_type'(z);
      return r;
   endfunction

   function automatic quat_row_type known_row(int w, int x, int y, int z,
                                              int d0, int d1, int d2, bit degen);
      quat_row_type r;
      r = row(w, x, y, z);
      r.known = 1'b1;
      r.m = '0;
      r.m.m00 = entry_type'(d0);
      r.m.m11 = entry_type'(d1);
      r.m.m22 = entry_type'(d2);
      r.m.degenerate = degen;
      return r;
   endfunction

   function automatic entry_type random_component();
      case ($urandom_range(0, 9))
         0: return entry_type'(-32768);
         1: return entry_type'(32767);
         2: return entry_type'($urandom_range(0, 3)) - 1;
         3: return entry_type'($urandom_range(0, 255)) - 128;
         default: return entry_type'($urandom);
      endcase
   endfunction

   // Beats are offered at the falling edge; acceptance is read at the rising
   // edges that follow. Valid stays high into the next call so that beats can
   // follow back to back.
   task automatic send_quaternion(entry_type qw, entry_type qx, entry_type qy, entry_type qz,
                                  bit directed_known, matrix_type typed);
      matrix_type predicted;
      predicted = rotation_of(qw, qx, qy, qz);
      if (directed_known && predicted !== typed) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with predictor: %h vs %h", typed, predicted);
      end
      while (!calm_window && $urandom_range(0, 99) < 10) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.qw <= qw;
      req_ch.qx <= qx;
      req_ch.qy <= qy;
      req_ch.qz <= qz;
      do @(posedge clock); while (!req_ch.ready);
      pending_matrices.push_back(predicted);
      @(negedge clock);
   endtask

   quat_row_type stimulus_table[] = '{
      known_row(0, 0, 0, 0, ONE, ONE, ONE, 1'b1),
      known_row(ONE, 0, 0, 0, ONE, ONE, ONE, 1'b0),
      known_row(-ONE, 0, 0, 0, ONE, ONE, ONE, 1'b0),
      known_row(32767, 0, 0, 0, ONE, ONE, ONE, 1'b0),
      known_row(-32768, 0, 0, 0, ONE, ONE, ONE, 1'b0),
      known_row(0, ONE, 0, 0, ONE, -ONE, -ONE, 1'b0),
      known_row(0, 0, -32768, 0, -ONE, ONE, -ONE, 1'b0),
      known_row(0, 0, 0, 1, -ONE, -ONE, ONE, 1'b0),
      row(-32768, -32768, -32768, -32768),
      row(32767, 32767, 32767, 32767),
      row(32767, -32768, 32767, -32768),
      row(1, 1, 1, 1),
      row(1, 0, 0, -1),
      row(-1, 1, 0, 0),
      row(11585, 11585, 0, 0),
      row(11585, 0, -11585, 0),
      row(8192, 8192, 8192, 8192),
      row(16384, 100, -200, 300),
      row(3, 2, 1, 0),
      row(-21846, 5555, 12345, -30000)
   };

   initial begin
      req_ch.valid = 1'b0;
      req_ch.qw = '0;
      req_ch.qx = '0;
      req_ch.qy = '0;
      req_ch.qz = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stimulus_table[i])
         send_quaternion(stimulus_table[i].w, stimulus_table[i].x, stimulus_table[i].y,
                         stimulus_table[i].z, stimulus_table[i].known, stimulus_table[i].m);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         calm_window = (i >= 300 && i < 500);
         hold_off = (i >= 700 && i < 760);
         if (i == 1000) begin
            req_ch.valid <= 1'b0;
            do @(negedge clock); while (pending_matrices.size() != 0);
         end
         send_quaternion(random_component(), random_component(), random_component(),
                         random_component(), 1'b0, '0);
      end
      hold_off = 1'b0;
      calm_window = 1'b0;

      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_matrices.size() != 0);
      repeat (40) @(posedge clock);
      $display("Checked %0d rotation matrices, %0d of them degenerate, across extremes,",
               matrices_seen, degenerate_seen);
      $display("random quaternions, random gaps and a long response stall.");
      if (mismatches == 0 && pending_matrices.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Response side: random stalls, plus one long stall measured in cycles.
   initial begin
      int stall_cycles;
      rsp_ch.ready = 1'b0;
      stall_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_off && stall_cycles < 120) begin
            stall_cycles++;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm_window || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   always @(posedge clock) begin
      matrix_type seen, want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = {rsp_ch.m00, rsp_ch.m01, rsp_ch.m02, rsp_ch.m10, rsp_ch.m11,
                 rsp_ch.m12, rsp_ch.m20, rsp_ch.m21, rsp_ch.m22, rsp_ch.degenerate};
         matrices_seen++;
         if (seen.degenerate) degenerate_seen++;
         if (pending_matrices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected matrix beat: %h", seen);
         end else begin
            want = pending_matrices.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Matrix mismatch, expected / actual:");
                  $display("  %0d %0d %0d %0d %0d %0d %0d %0d %0d deg %b", want.m00,
                           want.m01, want.m02, want.m10, want.m11, want.m12, want.m20,
                           want.m21, want.m22, want.degenerate);
                  $display("  %0d %0d %0d %0d %0d %0d %0d %0d %0d deg %b", seen.m00,
                           seen.m01, seen.m02, seen.m10, seen.m11, seen.m12, seen.m20,
                           seen.m21, seen.m22, seen.degenerate);
               end
            end
         end
      end
   end
endmodule

>>> quaternion_to_rotation_matrix.f
rtl/qrm_pkg.sv
rtl/qrm_if.sv
rtl/qrm_div_lane.sv
rtl/quaternion_to_rotation_matrix.sv
tb/tb.sv
